>>> rtl/core/art_pkg.sv
// Package for the acknowledgement range tracker.
// Holds field widths, operation codes, the controller state type and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package art_pkg;

    localparam int PN_W            = 62;
    localparam int TIME_W          = 64;
    localparam int LR_W            = 63;
    localparam int FR_W            = 5;
    localparam int FR_MAX          = 31;
    localparam int OP_W            = 2;
    localparam int IN_TDATA_W      = 128;
    localparam int OUT_TDATA_W     = 136;
    localparam int TRACK_DEPTH_DEF = 32;
    localparam logic [1:0] PEND_SAT = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_RX    = 2'd0,
        OP_BUILD = 2'd1,
        OP_SENT  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic insert;
        logic clear;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> rtl/core/art_cell.sv
// One cell of the sorted packet number chain.
// Holds one tracked number and its valid bit and, on an insert, takes its neighbor's entry or the new number.
// Depends on art_pkg.
`timescale 1ns / 1ps
`default_nettype none

module art_cell import art_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cell_ctl       i_ctl,
    input  wire logic [PN_W-1:0] i_key,
    input  wire logic [PN_W-1:0] i_top,
    input  wire logic [PN_W-1:0] i_ins_pn,
    input  wire logic [PN_W-1:0] i_prev_num,
    input  wire logic            i_prev_valid,
    input  wire logic            i_prev_gt,
    output logic [PN_W-1:0]      o_num,
    output logic                 o_valid,
    output logic                 o_gt,
    output logic                 o_eq,
    output logic                 o_match
);

    logic [PN_W-1:0] r_num;
    logic            r_valid;
    logic            r_gt;
    logic            r_eq;
    logic            r_match;
    logic [PN_W:0]   w_sum;

    assign w_sum = {1'b0, r_num} + (PN_W+1)'(CELL_IDX);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_gt    <= r_valid && (r_num > i_key);
            r_eq    <= r_valid && (r_num == i_key);
            r_match <= r_valid && (w_sum == {1'b0, i_top});
        end
        if (i_ctl.insert && !r_gt) begin
            if (i_prev_gt) begin
                r_num <= i_ins_pn;
            end else begin
                r_num <= i_prev_num;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.insert && !r_gt) begin
            r_valid <= i_prev_gt ? 1'b1 : i_prev_valid;
        end
    end

    assign o_num   = r_num;
    assign o_valid = r_valid;
    assign o_gt    = r_gt;
    assign o_eq    = r_eq;
    assign o_match = r_match;

endmodule

`default_nettype wire

>>> rtl/core/ack_range_tracker.sv
// A request is registered with its cell compares when accepted; the cell update step then
// registers its result. No new request is taken until that cell update step is done.
// A request is accepted while the previous result still waits on the output register.
// Reset is synchronous and active low; it empties the chain and clears the pending count.
// Top level of the acknowledgement range tracker; depends on art_pkg and art_cell.
`timescale 1ns / 1ps
`default_nettype none

module ack_range_tracker import art_pkg::*; #(
    parameter int TRACK_DEPTH = TRACK_DEPTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // pn[61:0], time_us[125:62], zero fill[127:126]
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // op[1:0]
    input  wire logic [OP_W-1:0]        i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // ack_due[0], largest[63:1], ack_valid[64], delay[128:65],
    // first_range[133:129], zero fill[135:134]
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    localparam int FR_BITS = (TRACK_DEPTH - 1 < FR_MAX) ? TRACK_DEPTH - 1 : FR_MAX;

    t_state              r_state, n_state;
    t_op                 r_op;
    logic [PN_W-1:0]     r_pn;
    logic [TIME_W-1:0]   r_time;
    logic                r_any, n_any;
    logic [PN_W-1:0]     r_largest, n_largest;
    logic [TIME_W-1:0]   r_arrival, n_arrival;
    logic [1:0]          r_pend, n_pend;
    logic                r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out, n_out;

    t_cell_ctl           w_ctl;
    logic                w_accept;
    logic                w_go;
    logic                w_dup;
    logic                w_ack_valid;
    logic [TIME_W-1:0]   w_delay;
    logic [FR_W-1:0]     w_range;
    logic [LR_W-1:0]     w_lr;
    logic [FR_BITS-1:0]  w_run;

    logic [PN_W-1:0]        w_num [TRACK_DEPTH];
    logic [TRACK_DEPTH-1:0] w_valid;
    logic [TRACK_DEPTH-1:0] w_gt;
    logic [TRACK_DEPTH-1:0] w_eq;
    logic [TRACK_DEPTH-1:0] w_match;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_go            = (r_state == ST_EXEC) && (!r_out_valid || i_m_axis_tready);
    assign w_dup           = |w_eq;

    always_comb begin
        w_ctl.load   = w_accept;
        w_ctl.insert = w_go && (r_op == OP_RX) && !w_dup;
        w_ctl.clear  = w_go && (r_op == OP_CLEAR);
    end

    genvar g;
    generate
        for (g = 0; g < TRACK_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                art_cell #(.CELL_IDX(g)) u_cell (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_ctl       (w_ctl),
                    .i_key       (i_s_axis_tdata[PN_W-1:0]),
                    .i_top       (r_largest),
                    .i_ins_pn    (r_pn),
                    .i_prev_num  ({PN_W{1'b0}}),
                    .i_prev_valid(1'b0),
                    .i_prev_gt   (1'b1),
                    .o_num       (w_num[g]),
                    .o_valid     (w_valid[g]),
                    .o_gt        (w_gt[g]),
                    .o_eq        (w_eq[g]),
                    .o_match     (w_match[g])
                );
            end else begin : g_body
                art_cell #(.CELL_IDX(g)) u_cell (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_ctl       (w_ctl),
                    .i_key       (i_s_axis_tdata[PN_W-1:0]),
                    .i_top       (r_largest),
                    .i_ins_pn    (r_pn),
                    .i_prev_num  (w_num[g-1]),
                    .i_prev_valid(w_valid[g-1]),
                    .i_prev_gt   (w_gt[g-1]),
                    .o_num       (w_num[g]),
                    .o_valid     (w_valid[g]),
                    .o_gt        (w_gt[g]),
                    .o_eq        (w_eq[g]),
                    .o_match     (w_match[g])
                );
            end
        end
        for (g = 0; g < FR_BITS; g++) begin : g_run
            assign w_run[g] = w_match[g+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= t_op'(i_s_axis_tuser);
            r_pn   <= i_s_axis_tdata[PN_W-1:0];
            r_time <= i_s_axis_tdata[PN_W +: TIME_W];
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_any       <= 1'b0;
            r_largest   <= '0;
            r_arrival   <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_any       <= n_any;
            r_largest   <= n_largest;
            r_arrival   <= n_arrival;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_any       = r_any;
        n_largest   = r_largest;
        n_arrival   = r_arrival;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out       = r_out;
        w_ack_valid = 1'b0;
        w_delay     = '0;
        w_range     = '0;
        w_lr        = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_go) begin
                    case (r_op)
                        OP_RX: begin
                            if (!r_any || (r_pn > r_largest)) begin
                                n_largest = r_pn;
                                n_arrival = r_time;
                            end
                            n_any = 1'b1;
                            if (r_pend != PEND_SAT) begin
                                n_pend = r_pend + 2'd1;
                            end
                        end
                        OP_BUILD: begin
                            w_ack_valid = r_any && w_valid[0];
                            if (w_ack_valid) begin
                                if (r_time > r_arrival) begin
                                    w_delay = r_time - r_arrival;
                                end
                                w_range = FR_W'($countones(w_run));
                            end
                        end
                        OP_SENT: begin
                            n_pend = '0;
                        end
                        OP_CLEAR: begin
                            n_any     = 1'b0;
                            n_largest = '0;
                            n_arrival = '0;
                            n_pend    = '0;
                        end
                        default: begin
                            n_pend = r_pend;
                        end
                    endcase
                    w_lr        = n_any ? {1'b0, n_largest} : {LR_W{1'b1}};
                    n_out       = {2'b00, w_range, w_delay, w_ack_valid, w_lr,
                                   (n_pend == PEND_SAT)};
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

`ifndef SYNTHESIS
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("Tracked entries do not form a prefix of the chain.");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> w_valid[0])
        else $error("A packet was recorded but the head cell is empty.");

    a_head_largest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> (w_num[0] == r_largest))
        else $error("The head cell does not hold the largest packet number.");

    a_hold_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_out_valid && !i_m_axis_tready) |=> (r_state == ST_EXEC))
        else $error("A request completed while the result register was still full.");
`endif

endmodule

`default_nettype wire

>>> dv/ack_range_tracker_test.sv
// Self-checking testbench for ack_range_tracker: streams packet, build, sent and clear requests
// and checks every tracker report against a behavioral tracker kept in this file.
// Depends on art_pkg and the ack_range_tracker RTL.
`timescale 1ns / 1ps
`default_nettype none

module ack_range_tracker_test;
    import art_pkg::*;

    localparam int DEPTH        = TRACK_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam logic [PN_W-1:0] PN_MAX = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        t_op               op;
        logic [PN_W-1:0]   pn;
        logic [TIME_W-1:0] t;
    } t_request;

    typedef struct packed {
        logic              ack_due;
        logic [LR_W-1:0]   top_pn;
        logic              ack_valid;
        logic [TIME_W-1:0] delay;
        logic [FR_W-1:0]   first_range;
    } t_report;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    ack_range_tracker #(
        .TRACK_DEPTH(DEPTH)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    t_request          request_queue[$];
    t_report           report_queue[$];
    t_request          cur_req;
    t_request          next_req;
    logic [PN_W-1:0]   trk_num[DEPTH];
    bit                trk_vld[DEPTH];
    longint            largest_pn = -1;
    logic [TIME_W-1:0] largest_time = '0;
    int                pend_count = 0;
    logic [TIME_W-1:0] clock_now;
    int                accepted_total = 0;
    int                reports_seen = 0;
    int                mismatch_count = 0;
    int                op_count[4] = '{0, 0, 0, 0};
    int                acks_built = 0;
    int                longest_range = 0;
    int                dup_count = 0;
    int                drop_count = 0;
    int                gap_left = 0;
    int                stall_left = 0;
    int                cycle_count = 0;
    logic              hold_off = 1'b0;

    function automatic bit quiet_stretch();
        return ((accepted_total / 150) % 4) == 1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_stretch() || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PN_W-1:0] rand_pn();
        return PN_W'({$urandom, $urandom});
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        return {$urandom, $urandom};
    endfunction

    function automatic void clear_tracker();
        for (int i = 0; i < DEPTH; i++) trk_vld[i] = 1'b0;
        largest_pn = -1;
        largest_time = '0;
        pend_count = 0;
    endfunction

    function automatic t_report track_request(t_request req);
        t_report           rep;
        int                fill;
        int                pos;
        int                idx;
        logic [63:0]       top;
        logic [63:0]       run;
        rep = '0;
        case (req.op)
            OP_RX: begin
                if (longint'({2'b00, req.pn}) > largest_pn) begin
                    largest_pn = longint'({2'b00, req.pn});
                    largest_time = req.t;
                end
                fill = 0;
                while (fill < DEPTH && trk_vld[fill]) fill++;
                pos = 0;
                while (pos < fill && trk_num[pos] > req.pn) pos++;
                if (pos < fill && trk_num[pos] == req.pn) begin
                    dup_count++;
                end else if (pos >= DEPTH) begin
                    drop_count++;
                end else begin
                    if (fill == DEPTH) begin
                        fill = DEPTH - 1;
                        drop_count++;
                    end
                    for (int i = fill; i > pos; i--) begin
                        trk_num[i] = trk_num[i-1];
                        trk_vld[i] = 1'b1;
                    end
                    trk_num[pos] = req.pn;
                    trk_vld[pos] = 1'b1;
                end
                if (pend_count < 2) pend_count++;
            end
            OP_BUILD: begin
                if (largest_pn >= 0 && trk_vld[0]) begin
                    rep.ack_valid = 1'b1;
                    if (req.t > largest_time) rep.delay = req.t - largest_time;
                    top = 64'(largest_pn);
                    run = '0;
                    idx = 0;
                    while (idx < DEPTH && trk_vld[idx] && {2'b00, trk_num[idx]} == top - run) begin
                        run++;
                        idx++;
                    end
                    if (run > 0) run--;
                    rep.first_range = (run > 64'(FR_MAX)) ? FR_W'(FR_MAX) : run[FR_W-1:0];
                    acks_built++;
                    if (int'(rep.first_range) > longest_range)
                        longest_range = int'(rep.first_range);
                end
            end
            OP_SENT: begin
                pend_count = 0;
            end
            OP_CLEAR: begin
                clear_tracker();
            end
        endcase
        rep.ack_due = (pend_count >= 2);
        rep.top_pn = largest_pn[LR_W-1:0];
        return rep;
    endfunction

    function automatic void check_report(t_report got);
        t_report want;
        reports_seen++;
        if (report_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Unexpected report %0d: due=%0b largest=%0h valid=%0b delay=%0h range=%0d",
                         reports_seen, got.ack_due, got.top_pn, got.ack_valid,
                         got.delay, got.first_range);
            return;
        end
        want = report_queue.pop_front();
        if (got.ack_due !== want.ack_due || got.top_pn !== want.top_pn ||
            got.ack_valid !== want.ack_valid || got.delay !== want.delay ||
            got.first_range !== want.first_range) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("Report %0d mismatch:", reports_seen);
                $display("  expected due=%0b largest=%0h valid=%0b delay=%0h range=%0d",
                         want.ack_due, want.top_pn, want.ack_valid,
                         want.delay, want.first_range);
                $display("  actual   due=%0b largest=%0h valid=%0b delay=%0h range=%0d",
                         got.ack_due, got.top_pn, got.ack_valid,
                         got.delay, got.first_range);
            end
        end
    endfunction

    task automatic add_request(t_op op, logic [PN_W-1:0] pn, logic [TIME_W-1:0] t);
        t_request req;
        req.op = op;
        req.pn = pn;
        req.t = t;
        request_queue.insert(request_queue.size(), req);
    endtask

    task automatic add_build();
        if ($urandom_range(0, 99) < 6)
            add_request(OP_BUILD, rand_pn(), clock_now - TIME_W'($urandom_range(0, 500)));
        else
            add_request(OP_BUILD, rand_pn(), clock_now + TIME_W'($urandom_range(0, 300)));
    endtask

    // A flight of mostly ascending packet numbers with skips, repeats and late arrivals,
    // interleaved with ack builds and ack-sent markers as a receiver would issue them.
    task automatic add_flight();
        logic [PN_W-1:0] base;
        logic [PN_W-1:0] next_pn;
        logic [PN_W-1:0] pn;
        int              len;
        int              r;
        r = $urandom_range(0, 99);
        if (r < 30) base = PN_W'($urandom_range(0, 1000));
        else if (r < 80) base = rand_pn();
        else base = PN_MAX - PN_W'($urandom_range(0, 300));
        if (base > PN_MAX - PN_W'(200)) base = PN_MAX - PN_W'(200);
        if ($urandom_range(0, 99) < 30) clock_now = rand_time();
        next_pn = base;
        len = $urandom_range(1, 45);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            clock_now += TIME_W'($urandom_range(0, 1000));
            if (r < 6 && next_pn != base) begin
                pn = base + PN_W'($urandom_range(0, int'(next_pn - base) - 1));
            end else begin
                if (r < 12) next_pn += PN_W'($urandom_range(1, 3));
                pn = next_pn;
                next_pn += 1;
            end
            add_request(OP_RX, pn, clock_now);
            r = $urandom_range(0, 99);
            if (r < 18) add_build();
            else if (r < 24) add_request(OP_SENT, rand_pn(), rand_time());
        end
        add_build();
        if ($urandom_range(0, 99) < 4) add_request(OP_CLEAR, rand_pn(), rand_time());
    endtask

    task automatic add_noise();
        int r;
        int n;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40) add_request(OP_RX, rand_pn(), rand_time());
            else if (r < 70) add_request(OP_BUILD, rand_pn(), rand_time());
            else if (r < 90) add_request(OP_SENT, rand_pn(), rand_time());
            else add_request(OP_CLEAR, rand_pn(), rand_time());
        end
    endtask

    task automatic fill_requests();
        int target;
        add_request(OP_BUILD, rand_pn(), rand_time());
        add_request(OP_SENT, rand_pn(), rand_time());
        add_request(OP_RX, '0, 64'd100);
        add_request(OP_BUILD, rand_pn(), 64'd50);
        add_request(OP_RX, '0, 64'd200);
        add_request(OP_RX, PN_W'(1), '0);
        add_request(OP_BUILD, rand_pn(), TIME_MAX);
        add_request(OP_SENT, rand_pn(), rand_time());
        add_request(OP_RX, PN_MAX, TIME_MAX);
        add_request(OP_BUILD, rand_pn(), TIME_MAX);
        add_request(OP_RX, PN_MAX - PN_W'(1), '0);
        add_request(OP_RX, PN_MAX - PN_W'(3), '0);
        add_request(OP_BUILD, rand_pn(), '0);
        add_request(OP_CLEAR, rand_pn(), rand_time());
        add_request(OP_BUILD, rand_pn(), rand_time());
        add_request(OP_RX, rand_pn(), rand_time());
        add_request(OP_BUILD, '0, '0);
        add_request(OP_RX, PN_MAX, '0);
        add_request(OP_BUILD, PN_MAX, TIME_MAX);
        add_request(OP_CLEAR, PN_MAX, TIME_MAX);
        add_request(OP_SENT, PN_MAX, TIME_MAX);
        target = request_queue.size() + RANDOM_ITEMS;
        clock_now = rand_time();
        while (request_queue.size() < target) begin
            if ($urandom_range(0, 99) < 75) add_flight();
            else add_noise();
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                report_queue.insert(report_queue.size(), track_request(cur_req));
                op_count[cur_req.op]++;
                accepted_total++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    next_req = request_queue.pop_front();
                    cur_req = next_req;
                    s_tvalid <= 1'b1;
                    s_tdata <= {2'b00, next_req.t, next_req.pn};
                    s_tuser <= next_req.op;
                    gap_left = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_report({m_tdata[0], m_tdata[63:1], m_tdata[64], m_tdata[128:65],
                              m_tdata[133:129]});
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
            end
        end
    end

    // The receiver stops taking reports for a long stretch so the tracker backs up.
    initial begin
        while (accepted_total < 600) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d reports outstanding.",
                     cycle_count, report_queue.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        fill_requests();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (request_queue.size() > 0 || s_tvalid) @(posedge clk);
        while (report_queue.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d reports: %0d received, %0d builds (%0d acks), %0d sent, %0d clears.",
                 reports_seen, op_count[OP_RX], op_count[OP_BUILD], acks_built,
                 op_count[OP_SENT], op_count[OP_CLEAR]);
        $display("Duplicates %0d, dropped numbers %0d, longest first range %0d, mismatches %0d.",
                 dup_count, drop_count, longest_range, mismatch_count);
        if (mismatch_count == 0 && report_queue.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
